### src/llf_pkg.sv
// ============================================================================
// llf_pkg: shared constants for the lead-lag filter
// Holds the register indexes and the item modes.
// ============================================================================
package llf_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_C1 = 2'd0;
    localparam logic [1:0] REG_C2 = 2'd1;
    localparam logic [1:0] REG_C3 = 2'd2;
    localparam logic [1:0] REG_C4 = 2'd3;
    localparam int         REG_COUNT = 4;

    // Item modes
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_PRESET = 1'b1;

endpackage

### src/llf_div.sv
// ============================================================================
// llf_div: restoring divider, one quotient bit per cycle
// Computes round(num / den) with ties away from zero, unsigned.
// ============================================================================
module llf_div #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 34
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              busy,
    output logic              done,
    output logic [NUM_W-1:0]  quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] rsh;

    // Remainder shifted by one numerator bit and trial subtract
    assign rsh   = {r_reg, q_reg[NUM_W-1]};
    assign trial = rsh - {2'b00, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift-subtract; the rounding correction is added combinationally on quo
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W+1])
            begin
                r_reg <= trial[DEN_W:0];
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rsh[DEN_W:0];
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Round up when twice the remainder reaches the divisor (ties away from zero)
    assign quo  = q_reg + NUM_W'(({r_reg, 1'b0} >= {2'b00, d_reg}) ? 1 : 0);
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

### src/llf_mac.sv
// ============================================================================
// llf_mac: signed shift-add multiplier, one multiplier bit per cycle
// Produces the full signed product of two operands.
// ============================================================================
module llf_mac #(
    parameter int A_W = 32,
    parameter int B_W = 34
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [A_W-1:0] a,
    input  logic signed [B_W-1:0] b,
    output logic                  done,
    output logic signed [A_W+B_W-1:0] prod
);
    localparam int PW = A_W + B_W;
    localparam int CW = $clog2(B_W + 1);

    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] mcand_reg;
    logic [B_W-1:0]       mplier_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One partial product a cycle; the top multiplier bit has negative weight
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= PW'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                if (cnt_reg == CW'(1))
                    acc_reg <= acc_reg - mcand_reg;
                else
                    acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

### src/lead_lag_filter_tustin_core.sv
// ============================================================================
// lead_lag_filter_tustin_core: Tustin-discretized lead-lag element
// Bit-serial sequencer with one shared multiplier and one shared divider.
// ============================================================================
// Usage
// The s_axis channel carries one item: tdata = {time_step, sample_in} (sample
// in the low DATA_WIDTH bits, then the step), tuser = mode. The m_axis channel
// returns one item per input: tdata = filter_out, tuser = {saturated, div_fault}
// with div_fault in bit 0. Gains are written through cfg_we/cfg_addr/cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce it. A preset or a hold item goes from S_IDLE through S_OUT,
// which loads the output register. A filter item runs two step products
// (S_MUL_C2, S_MUL_C4, S_DEN), three coefficient divisions (the quotient being
// 2*DATA_WIDTH bits wide at the default widths) and three sample products, then
// S_FINISH rounds and clips the sum and S_OUT loads the output; a zero
// denominator skips from S_DIV to S_OUT with div_fault set. The serial
// multiplier and divider each retire one bit a cycle. One item is in work at a
// time; s_axis_tready is low from acceptance until the result has been taken.
// Reset clears the gains, both history values and the sequencer.
// A stalled receiver holds the result in the output register until
// m_axis_tready.
// ============================================================================
module lead_lag_filter_tustin_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [DATA_WIDTH-1:0]      cfg_data,
    // Input items
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: sample_in, time_step, zero fill
    input  logic [((2*DATA_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
    // Fields from bit 0: mode
    input  logic                       s_axis_tuser,
    // Result items
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // Fields from bit 0: filter_out, zero fill
    output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // Fields from bit 0: div_fault, saturated
    output logic [1:0]                 m_axis_tuser
);
    import llf_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int SW   = W - 1;
    localparam int PW   = 2 * W;         // product width
    // Numerators and denominator: 2*c plus a rounded step product
    localparam int NW   = (2*W - F > W + 2) ? 2*W - F : W + 2;
    localparam int UW   = NW + F;        // shifted numerator magnitude
    localparam int SUMW = PW + 2;        // sum of three products
    localparam int OW   = ((W+7)/8)*8;
    localparam logic signed [SUMW-1:0] DMAX = SUMW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [SUMW-1:0] DMIN = -DMAX - SUMW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_C2, S_MUL_C4, S_DEN, S_DIV, S_DIV_WAIT,
        S_MUL_Y, S_MUL_Y_WAIT, S_FINISH, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [W-1:0] c1_reg, c2_reg, c3_reg, c4_reg;
    logic signed [W-1:0] prev_in_reg, prev_out_reg;
    logic signed [W-1:0] u_reg;
    logic [SW-1:0]       dt_reg;
    logic signed [NW-1:0] dtc2_reg, dtc4_reg;
    logic signed [W-1:0] coef_reg [3];
    logic [1:0]          idx_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic                sat_reg, fault_reg;
    logic [W-1:0]        out_data_reg;
    logic [1:0]          out_user_reg;
    logic                out_valid_reg;

    // Shared serial multiplier
    logic                 mul_start;
    logic signed [W-1:0]  mul_a;
    logic signed [W-1:0]  mul_b;
    logic                 mul_done;
    logic signed [PW-1:0] mul_p;

    llf_mac #(.A_W(W), .B_W(W)) u_mac (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .prod(mul_p)
    );

    // Shared serial divider
    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic [UW-1:0]        div_num;
    logic [NW-1:0]        div_den;
    logic [UW-1:0]        div_q;

    llf_div #(.NUM_W(UW), .DEN_W(NW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .done(div_done), .quo(div_q)
    );

    // Operand selection
    logic signed [NW-1:0] two_c1, two_c3, den, num_sel;
    logic                 neg_sel;
    logic signed [PW-1:0] rnd_p;
    logic signed [NW-1:0] rnd_v;
    logic [UW-1:0]        qlim_pos;
    logic signed [W-1:0]  coef_val;
    logic                 coef_sat;

    assign two_c1 = NW'(c1_reg) <<< 1;
    assign two_c3 = NW'(c3_reg) <<< 1;
    assign den    = two_c3 + dtc4_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    num_sel = two_c1 + dtc2_reg;
            2'd1:    num_sel = dtc2_reg - two_c1;
            default: num_sel = two_c3 - dtc4_reg;
        endcase
    end

    assign neg_sel = num_sel[NW-1] ^ den[NW-1];
    assign div_num = {(num_sel[NW-1] ? NW'(-num_sel) : num_sel), {F{1'b0}}};
    assign div_den = den[NW-1] ? NW'(-den) : den;

    // Step product rounded half up to fixed point
    assign rnd_p = (mul_p + (PW'(1) <<< (F-1))) >>> F;
    assign rnd_v = NW'(rnd_p);

    // Coefficient clip: magnitude limit differs by sign
    assign qlim_pos = UW'(DMAX);
    always_comb
    begin
        coef_sat = 1'b0;
        if (neg_sel)
        begin
            if (div_q > qlim_pos + UW'(1))
            begin
                coef_sat = 1'b1;
                coef_val = W'(DMIN);
            end
            else
                coef_val = W'(-div_q);
        end
        else if (div_q > qlim_pos)
        begin
            coef_sat = 1'b1;
            coef_val = W'(DMAX);
        end
        else
            coef_val = W'(div_q);
    end

    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a = c2_reg;
        mul_b = $signed({1'b0, dt_reg});
        case (state_reg)
            S_MUL_C2: mul_start = 1'b1;
            S_MUL_C4:
            begin
                mul_a = c4_reg;
                mul_start = mul_done;
            end
            S_DIV:    div_start = (den != '0);
            S_MUL_Y:
            begin
                mul_start = 1'b1;
                mul_b = coef_reg[idx_reg];
                case (idx_reg)
                    2'd0:    mul_a = u_reg;
                    2'd1:    mul_a = prev_in_reg;
                    default: mul_a = prev_out_reg;
                endcase
            end
            default: ;
        endcase
    end

    // Final sum rounded half up and clipped
    logic signed [SUMW-1:0] y_full;
    assign y_full = (sum_reg + (SUMW'(1) <<< (F-1))) >>> F;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            c1_reg        <= '0;
            c2_reg        <= '0;
            c3_reg        <= '0;
            c4_reg        <= '0;
            prev_in_reg   <= '0;
            prev_out_reg  <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_C1:  c1_reg <= cfg_data;
                    REG_C2:  c2_reg <= cfg_data;
                    REG_C3:  c3_reg <= cfg_data;
                    REG_C4:  c4_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        u_reg     <= s_axis_tdata[W-1:0];
                        dt_reg    <= s_axis_tdata[W+SW-1:W];
                        sat_reg   <= 1'b0;
                        fault_reg <= 1'b0;
                        if (s_axis_tuser == MODE_PRESET)
                        begin
                            prev_out_reg <= s_axis_tdata[W-1:0];
                            state_reg    <= S_OUT;
                        end
                        else if (s_axis_tdata[W+SW-1:W] == '0)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_MUL_C2;
                    end
                end
                S_MUL_C2: state_reg <= S_MUL_C4;
                S_MUL_C4:
                begin
                    if (mul_done)
                    begin
                        dtc2_reg  <= rnd_v;
                        state_reg <= S_DEN;
                    end
                end
                S_DEN:
                begin
                    if (mul_done)
                    begin
                        dtc4_reg  <= rnd_v;
                        idx_reg   <= 2'd0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (den == '0)
                    begin
                        fault_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        coef_reg[idx_reg] <= coef_val;
                        if (coef_sat)
                            sat_reg <= 1'b1;
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= 2'd0;
                            sum_reg   <= '0;
                            state_reg <= S_MUL_Y;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_MUL_Y: state_reg <= S_MUL_Y_WAIT;
                S_MUL_Y_WAIT:
                begin
                    if (mul_done)
                    begin
                        sum_reg <= sum_reg + SUMW'(mul_p);
                        if (idx_reg == 2'd2)
                            state_reg <= S_FINISH;
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= S_MUL_Y;
                        end
                    end
                end
                S_FINISH:
                begin
                    prev_in_reg <= u_reg;
                    if (y_full > DMAX)
                    begin
                        prev_out_reg <= W'(DMAX);
                        sat_reg      <= 1'b1;
                    end
                    else if (y_full < DMIN)
                    begin
                        prev_out_reg <= W'(DMIN);
                        sat_reg      <= 1'b1;
                    end
                    else
                        prev_out_reg <= W'(y_full);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= prev_out_reg;
                    out_user_reg  <= {sat_reg, fault_reg};
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'(out_data_reg);
    assign m_axis_tuser  = out_user_reg;

    // A fault result never reports saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("fault and saturation both set");

    // The divider is never started while it is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // No new item is taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> !s_axis_tready)
        else $error("input accepted while result pending");

endmodule

### verif/lead_lag_filter_tustin_core_test.sv
// ============================================================================
// lead_lag_filter_tustin_core_test: self-checking bench for the lead-lag core
// Drives directed and random items with random idling on both sides, predicts
// each result with a bit-exact Q16.16 Tustin model and compares field by field.
// ============================================================================
`timescale 1ns / 100ps

module lead_lag_filter_tustin_core_test;
    import llf_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam longint DMAX = 64'sd2147483647;
    localparam longint DMIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] out_val;
        logic        fault;
        logic        sat;
    } result_t;

    typedef struct {
        logic        mode;
        logic [31:0] sample;
        logic [30:0] step;
        logic        has_exp;
        logic [31:0] exp_out;
        logic        exp_fault;
        logic        exp_sat;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Predictor state and gains
    longint gain_c1, gain_c2, gain_c3, gain_c4;
    longint hist_in, hist_out;

    result_t expected_results[$];
    int      mismatch_count;
    bit      no_idle;
    bit      hold_off_req;
    int      hold_off_cycles;

    lead_lag_filter_tustin_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Floor division by 2^n; arithmetic shift floors in two's complement.
    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    // Coefficient quotient rounded to nearest, ties away from zero, clipped.
    function automatic longint coef_quot(longint num, longint den, inout bit sat);
        bit neg;
        longint unsigned un, ud, q;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? longint'(-num) : num;
        ud = (den < 0) ? longint'(-den) : den;
        un = un << FB;
        q = (un + ud / 2) / ud;
        if (neg)
        begin
            if (q > 64'd2147483648)
            begin
                sat = 1'b1;
                return DMIN;
            end
            return -longint'(q);
        end
        if (q > 64'd2147483647)
        begin
            sat = 1'b1;
            return DMAX;
        end
        return longint'(q);
    endfunction

    // Advance the filter state by one item and return its result.
    function automatic result_t tustin_step(logic mode, logic [31:0] sample,
                                            logic [30:0] step);
        result_t r;
        longint u, dt, dt_c2, dt_c4, den, ca, cb, cc, p0, p1, p2, hi, lo, y;
        bit sat, fault;
        sat = 1'b0;
        fault = 1'b0;
        u = longint'(signed'(sample));
        dt = longint'(step);
        if (mode == MODE_PRESET)
        begin
            hist_out = u;
        end
        else if (dt > 0)
        begin
            dt_c2 = floor_shr(dt * gain_c2 + (64'sd1 << (FB - 1)), FB);
            dt_c4 = floor_shr(dt * gain_c4 + (64'sd1 << (FB - 1)), FB);
            den = 2 * gain_c3 + dt_c4;
            if (den == 0)
            begin
                fault = 1'b1;
            end
            else
            begin
                ca = coef_quot(2 * gain_c1 + dt_c2, den, sat);
                cb = coef_quot(dt_c2 - 2 * gain_c1, den, sat);
                cc = coef_quot(2 * gain_c3 - dt_c4, den, sat);
                p0 = u * ca;
                p1 = hist_in * cb;
                p2 = hist_out * cc;
                hi = floor_shr(p0, FB) + floor_shr(p1, FB) + floor_shr(p2, FB);
                lo = (p0 & 64'hFFFF) + (p1 & 64'hFFFF) + (p2 & 64'hFFFF);
                y = hi + ((lo + (64'sd1 << (FB - 1))) >>> FB);
                if (y > DMAX)
                begin
                    y = DMAX;
                    sat = 1'b1;
                end
                else if (y < DMIN)
                begin
                    y = DMIN;
                    sat = 1'b1;
                end
                hist_in = u;
                hist_out = y;
            end
        end
        r.out_val = hist_out[31:0];
        r.fault = fault;
        r.sat = sat;
        return r;
    endfunction

    // Write one gain register and mirror it in the predictor.
    task automatic write_gain(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_C1: gain_c1 = longint'(signed'(val));
            REG_C2: gain_c2 = longint'(signed'(val));
            REG_C3: gain_c3 = longint'(signed'(val));
            default: gain_c4 = longint'(signed'(val));
        endcase
    endtask

    task automatic set_gains(logic [31:0] c1, logic [31:0] c2, logic [31:0] c3,
                             logic [31:0] c4);
        write_gain(REG_C1, c1);
        write_gain(REG_C2, c2);
        write_gain(REG_C3, c3);
        write_gain(REG_C4, c4);
    endtask

    // Stop offering, wait until every result is in, then let the sequencer settle.
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    // Offer one item, predict its result, and wait for acceptance.
    // The item stays offered until the next item, a gap or a drain replaces it.
    task automatic send_item(logic mode, logic [31:0] sample, logic [30:0] step);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {1'b0, step, sample};
        expected_results.push_back(tustin_step(mode, sample, step));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random item: mostly filter steps with small to moderate time steps.
    task automatic send_random_item;
        logic mode;
        logic [31:0] sample;
        logic [30:0] step;
        mode = ($urandom_range(0, 9) == 0) ? MODE_PRESET : MODE_FILTER;
        case ($urandom_range(0, 4))
            0: sample = $urandom();
            1: sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: sample = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
        case ($urandom_range(0, 7))
            0: step = '0;
            1: step = 31'($urandom());
            2: step = 31'($urandom_range(1, 16));
            default: step = 31'($urandom_range(1, 32'h0002_0000));
        endcase
        send_item(mode, sample, step);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item: out=%h user=%b",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== want.out_val || m_axis_tuser[0] !== want.fault
                    || m_axis_tuser[1] !== want.sat)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp out=%h fault=%b sat=%b, got %h %b %b",
                                 want.out_val, want.fault, want.sat, m_axis_tdata,
                                 m_axis_tuser[0], m_axis_tuser[1]);
                end
            end
        end
    end

    // Timeout guard.
    initial
    begin
        #50ms;
        $display("** lead_lag_filter_tustin_core: FAILED **");
        $finish;
    end

    // Directed rows; expected values given where obvious from the rules.
    row_t directed[] = '{
        '{MODE_FILTER, 32'h0001_0000, 31'h0001_0000, 1'b1, 32'h0, 1'b1, 1'b0},
        '{MODE_FILTER, 32'h7FFF_FFFF, 31'h0, 1'b1, 32'h0, 1'b0, 1'b0},
        '{MODE_PRESET, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
        '{MODE_PRESET, 32'h7FFF_FFFF, 31'h0, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
        '{MODE_FILTER, 32'h1234_5678, 31'h0, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
        '{MODE_PRESET, 32'h0, 31'h0, 1'b1, 32'h0, 1'b0, 1'b0}
    };

    row_t gain_rows[] = '{
        '{MODE_FILTER, 32'h0001_0000, 31'h0000_0001, 1'b0, 0, 0, 0},
        '{MODE_FILTER, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 0, 0, 0},
        '{MODE_FILTER, 32'h8000_0000, 31'h0000_4000, 1'b0, 0, 0, 0},
        '{MODE_FILTER, 32'hFFFF_FFFF, 31'h0001_0000, 1'b0, 0, 0, 0},
        '{MODE_PRESET, 32'h0002_0000, 31'h0, 1'b0, 0, 0, 0},
        '{MODE_FILTER, 32'h0, 31'h0000_1000, 1'b0, 0, 0, 0},
        '{MODE_FILTER, 32'h0003_0000, 31'h0, 1'b0, 0, 0, 0}
    };

    // Main stimulus.
    initial
    begin
        result_t pred;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_FILTER;
        gain_c1 = 0;
        gain_c2 = 0;
        gain_c3 = 0;
        gain_c4 = 0;
        hist_in = 0;
        hist_out = 0;
        mismatch_count = 0;
        no_idle = 1'b0;
        hold_off_req = 1'b0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset gains: zero denominator, then holds and presets.
        foreach (directed[i])
        begin
            pred = tustin_step(directed[i].mode, directed[i].sample, directed[i].step);
            if (directed[i].has_exp && (pred.out_val !== directed[i].exp_out
                || pred.fault !== directed[i].exp_fault
                || pred.sat !== directed[i].exp_sat))
            begin
                mismatch_count++;
                $display("directed row %0d disagrees with predictor", i);
            end
        end
        hist_out = 0;
        hist_in = 0;
        foreach (directed[i])
        begin
            send_item(directed[i].mode, directed[i].sample, directed[i].step);
            if (directed[i].has_exp)
            begin
                pred.out_val = directed[i].exp_out;
                pred.fault = directed[i].exp_fault;
                pred.sat = directed[i].exp_sat;
                expected_results[$] = pred;
            end
        end
        drain_results();

        // Gain settings including extremes, each with the same gain_rows items.
        for (int g = 0; g < 4; g++)
        begin
            case (g)
                0: set_gains(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
                1: set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
                2: set_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                default: set_gains(32'h0, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
            endcase
            foreach (gain_rows[i])
                send_item(gain_rows[i].mode, gain_rows[i].sample, gain_rows[i].step);
            drain_results();
        end

        // Random phases with random gains, one long receiver hold-off.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph % 3 == 0)
                set_gains($urandom(), $urandom(), $urandom(), $urandom());
            else
                set_gains($urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                          $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                          $urandom_range(0, 32'h0004_0000),
                          $urandom_range(0, 32'h0004_0000));
            if (ph == 2)
            begin
                hold_off_cycles = 2000;
                hold_off_req = 1'b1;
            end
            if (ph == 8)
                no_idle = 1'b1;
            for (int n = 0; n < 200; n++)
            begin
                send_random_item();
                if (n == 100)
                begin
                    // Sender pause until everything outstanding has returned.
                    s_axis_tvalid <= 1'b0;
                    while (expected_results.size() != 0)
                        @(negedge clk);
                end
            end
            drain_results();
        end

        if (mismatch_count == 0)
            $display("** lead_lag_filter_tustin_core: PASSED **");
        else
            $display("** lead_lag_filter_tustin_core: FAILED **");
        $finish;
    end

endmodule

### files.f
src/llf_pkg.sv
src/llf_div.sv
src/llf_mac.sv
src/lead_lag_filter_tustin_core.sv
verif/lead_lag_filter_tustin_core_test.sv
